[design/hhd_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package hhd_pkg;

    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned LEN_W     = 16;
    localparam int unsigned KIND_W    = 2;
    localparam int unsigned HCOUNT_W  = 3;

    localparam logic [LEN_W-1:0] MAX_PAYLOAD_RST = 16'd1024;

    localparam logic [KIND_W-1:0] KIND_CMD   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ACL   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_SCO   = 2'd2;
    localparam logic [KIND_W-1:0] KIND_EVENT = 2'd3;

    localparam logic [BYTE_W-1:0] TYPE_CODE_FIRST = 8'd1;
    localparam logic [BYTE_W-1:0] TYPE_CODE_LAST  = 8'd4;

    // ACL low length byte sits at this header position (counted from 1)
    localparam logic [HCOUNT_W-1:0] ACL_LEN_LOW_POS = 3'd3;

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_HEADER  = 2'd1,
        PH_PAYLOAD = 2'd2
    } t_phase;

    typedef enum logic [2:0] {
        ST_TYPE     = 3'd0,
        ST_HEADER   = 3'd1,
        ST_PAYLOAD  = 3'd2,
        ST_UNKNOWN  = 3'd3,
        ST_OVERSIZE = 3'd4
    } t_status;

    typedef struct packed {
        t_status             status;
        logic [KIND_W-1:0]   packet_kind;
        logic [BYTE_W-1:0]   data_byte;
        logic [LEN_W-1:0]    payload_length;
        logic                last;
    } t_result;

    // header bytes following the type byte, per packet kind
    function automatic logic [HCOUNT_W-1:0] header_total(input logic [KIND_W-1:0] kind);
        logic [HCOUNT_W-1:0] total;
        case (kind)
            KIND_CMD:   total = 3'd3;
            KIND_ACL:   total = 3'd4;
            KIND_SCO:   total = 3'd3;
            KIND_EVENT: total = 3'd2;
            default:    total = 3'd3;
        endcase
        return total;
    endfunction

endpackage

`default_nettype wire

[design/hhd_in_stage.sv]
`timescale 1ns / 1ps
`default_nettype none

module hhd_in_stage (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_in_valid,
    output logic                            o_in_stall,
    input  wire logic [hhd_pkg::BYTE_W-1:0] i_rx_byte,
    input  wire logic                       i_adv,
    output logic                            o_valid,
    output logic [hhd_pkg::BYTE_W-1:0]      o_byte
);
    import hhd_pkg::*;

    logic              r_valid;
    logic              n_valid;
    logic [BYTE_W-1:0] r_byte;
    logic              accept;

    // held beat blocks a new one only if it cannot move on this cycle
    assign o_in_stall = r_valid && !i_adv;
    assign accept     = i_in_valid && !o_in_stall;

    always_comb begin
        if (accept) begin
            n_valid = 1'b1;
        end else if (i_adv) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_byte <= i_rx_byte;
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;

endmodule

`default_nettype wire

[design/hhd_parser.sv]
`timescale 1ns / 1ps
`default_nettype none

module hhd_parser (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_we,
    input  wire logic [hhd_pkg::LEN_W-1:0]  i_cfg_wdata,
    input  wire logic                       i_adv,
    input  wire logic [hhd_pkg::BYTE_W-1:0] i_byte,
    output hhd_pkg::t_result                o_result
);
    import hhd_pkg::*;

    t_phase              r_phase;
    t_phase              n_phase;
    logic [KIND_W-1:0]   r_kind;
    logic [KIND_W-1:0]   n_kind;
    logic [HCOUNT_W-1:0] r_header_count;
    logic [HCOUNT_W-1:0] n_header_count;
    logic [BYTE_W-1:0]   r_length_low;
    logic [BYTE_W-1:0]   n_length_low;
    logic [LEN_W-1:0]    r_payload_remaining;
    logic [LEN_W-1:0]    n_payload_remaining;
    logic [LEN_W-1:0]    r_length_seen;
    logic [LEN_W-1:0]    n_length_seen;
    logic [LEN_W-1:0]    r_max_payload;

    logic [HCOUNT_W-1:0] hc_inc;
    logic                hdr_more;
    logic [LEN_W-1:0]    len_dec;
    logic                oversize;
    logic                len_zero;
    logic [LEN_W-1:0]    rem_dec;
    logic                pay_end;
    logic                type_ok;
    logic [KIND_W-1:0]   type_kind;

    assign hc_inc    = r_header_count + 3'd1;
    assign hdr_more  = hc_inc < header_total(r_kind);
    assign len_dec   = (r_kind == KIND_ACL) ? {i_byte, r_length_low}
                                            : {{(LEN_W-BYTE_W){1'b0}}, i_byte};
    assign oversize  = len_dec > r_max_payload;
    assign len_zero  = len_dec == '0;
    assign rem_dec   = r_payload_remaining - 16'd1;
    assign pay_end   = rem_dec == '0;
    assign type_ok   = i_byte inside {[TYPE_CODE_FIRST:TYPE_CODE_LAST]};
    assign type_kind = KIND_W'(i_byte - 8'd1);

    // next state
    always_comb begin
        n_phase             = r_phase;
        n_kind              = r_kind;
        n_header_count      = r_header_count;
        n_length_low        = r_length_low;
        n_payload_remaining = r_payload_remaining;
        n_length_seen       = r_length_seen;
        case (r_phase)
            PH_HEADER: begin
                n_header_count = hc_inc;
                if (hdr_more) begin
                    if (r_kind == KIND_ACL && hc_inc == ACL_LEN_LOW_POS) begin
                        n_length_low = i_byte;
                    end
                end else begin
                    n_length_seen = len_dec;
                    if (oversize || len_zero) begin
                        n_phase = PH_IDLE;
                    end else begin
                        n_payload_remaining = len_dec;
                        n_phase             = PH_PAYLOAD;
                    end
                end
            end
            PH_PAYLOAD: begin
                n_payload_remaining = rem_dec;
                if (pay_end) begin
                    n_phase = PH_IDLE;
                end
            end
            default: begin
                n_phase = PH_IDLE;
                if (type_ok) begin
                    n_kind              = type_kind;
                    n_header_count      = '0;
                    n_length_low        = '0;
                    n_length_seen       = '0;
                    n_payload_remaining = '0;
                    n_phase             = PH_HEADER;
                end
            end
        endcase
    end

    // result for the byte now in the input register
    always_comb begin
        o_result.data_byte      = i_byte;
        o_result.packet_kind    = r_kind;
        o_result.payload_length = '0;
        o_result.last           = 1'b0;
        o_result.status         = ST_HEADER;
        case (r_phase)
            PH_HEADER: begin
                if (!hdr_more) begin
                    if (oversize) begin
                        o_result.status         = ST_OVERSIZE;
                        o_result.payload_length = len_dec;
                        o_result.last           = 1'b1;
                    end else if (len_zero) begin
                        o_result.last = 1'b1;
                    end else begin
                        o_result.payload_length = len_dec;
                    end
                end
            end
            PH_PAYLOAD: begin
                o_result.status         = ST_PAYLOAD;
                o_result.payload_length = r_length_seen;
                o_result.last           = pay_end;
            end
            default: begin
                if (type_ok) begin
                    o_result.status      = ST_TYPE;
                    o_result.packet_kind = type_kind;
                end else begin
                    o_result.status      = ST_UNKNOWN;
                    o_result.packet_kind = KIND_CMD;
                    o_result.last        = 1'b1;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase             <= PH_IDLE;
            r_kind              <= '0;
            r_header_count      <= '0;
            r_length_low        <= '0;
            r_payload_remaining <= '0;
            r_length_seen       <= '0;
        end else if (i_adv) begin
            r_phase             <= n_phase;
            r_kind              <= n_kind;
            r_header_count      <= n_header_count;
            r_length_low        <= n_length_low;
            r_payload_remaining <= n_payload_remaining;
            r_length_seen       <= n_length_seen;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_payload <= MAX_PAYLOAD_RST;
        end else if (i_cfg_we) begin
            r_max_payload <= i_cfg_wdata;
        end
    end

endmodule

`default_nettype wire

[design/hhd_out_stage.sv]
`timescale 1ns / 1ps
`default_nettype none

module hhd_out_stage (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_load,
    input  wire hhd_pkg::t_result i_result,
    output logic                  o_free,
    output logic                  o_out_valid,
    input  wire logic             i_out_stall,
    output hhd_pkg::t_result      o_result
);
    import hhd_pkg::*;

    logic    r_valid;
    logic    n_valid;
    t_result r_result;

    // free when empty or when the held beat leaves this cycle
    assign o_free = !r_valid || !i_out_stall;

    always_comb begin
        if (i_load) begin
            n_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_out_valid = r_valid;
    assign o_result    = r_result;

endmodule

`default_nettype wire

[design/hci_h4_packet_deframer_unit.sv]
// HCI H4 receive deframer.
// Input channel: i_in_valid / o_in_stall carry one received byte (i_rx_byte)
// per beat. Output channel: o_out_valid / i_out_stall carry one tagged beat
// per input byte: status (type, header, payload, unknown type dropped,
// oversize dropped), packet kind, the byte itself, the decoded payload
// length and a last flag on the final byte of a packet or dropped frame.
// i_cfg_we / i_cfg_wdata write the max payload length; write it only while
// no bytes are in flight.
// A byte accepted into the input register is parsed and loaded into the
// output register, from which it is offered on the output.
// Throughput: one byte per cycle unless the receiver stalls; the parse
// and state update form a single stage between the two registers.
// Reset (synchronous, active low) empties both registers, returns the
// parser to waiting for a type byte and sets max payload to 1024.
// When the receiver stalls, the output beat holds; the input register then
// keeps one more byte and o_in_stall rises until the output drains.
`timescale 1ns / 1ps
`default_nettype none

module hci_h4_packet_deframer_unit (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_we,
    input  wire logic [hhd_pkg::LEN_W-1:0]  i_cfg_wdata,
    input  wire logic                       i_in_valid,
    output logic                            o_in_stall,
    input  wire logic [hhd_pkg::BYTE_W-1:0] i_rx_byte,
    output logic                            o_out_valid,
    input  wire logic                       i_out_stall,
    output logic [2:0]                      o_status,
    output logic [hhd_pkg::KIND_W-1:0]      o_packet_kind,
    output logic [hhd_pkg::BYTE_W-1:0]      o_data_byte,
    output logic [hhd_pkg::LEN_W-1:0]       o_payload_length,
    output logic                            o_last
);
    import hhd_pkg::*;

    logic              in_valid;
    logic [BYTE_W-1:0] in_byte;
    logic              out_free;
    logic              adv;
    t_result           parse_result;
    t_result           out_result;

    assign adv = in_valid && out_free;

    hhd_in_stage u_in_stage (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_rx_byte  (i_rx_byte),
        .i_adv      (adv),
        .o_valid    (in_valid),
        .o_byte     (in_byte)
    );

    hhd_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_adv       (adv),
        .i_byte      (in_byte),
        .o_result    (parse_result)
    );

    hhd_out_stage u_out_stage (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (adv),
        .i_result    (parse_result),
        .o_free      (out_free),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_result    (out_result)
    );

    assign o_status         = out_result.status;
    assign o_packet_kind    = out_result.packet_kind;
    assign o_data_byte      = out_result.data_byte;
    assign o_payload_length = out_result.payload_length;
    assign o_last           = out_result.last;

endmodule

`default_nettype wire
